FILE: rtl/tset_pkg.sv
// Package: shared types and constants for the time sorted event table.
`timescale 1ns / 1ps
`default_nettype none
package tset_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MAX_RESULTS = 16;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_EXPIRE = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] event_start;
        logic [31:0] event_length;
        logic [31:0] event_payload;
        logic [47:0] now_time;
        logic [4:0]  max_matches;
    } req_t;

    typedef struct packed {
        logic        match_found;
        logic [47:0] match_start;
        logic [31:0] match_length;
        logic [31:0] match_payload;
        logic [4:0]  removed_count;
        logic [4:0]  entry_count;
        logic        last_result;
    } rsp_t;

    typedef struct packed {
        logic [47:0] start;
        logic [31:0] length;
        logic [31:0] payload;
    } entry_t;

    // Compare results from the shared compare unit.
    typedef struct packed {
        logic start_gt;   // entry start > key start
        logic started;    // entry start <= now
        logic ended;      // start + length <= now
    } cmp_t;
endpackage
`default_nettype wire

FILE: rtl/tset_cmp.sv
// Shared compare unit: one entry against the request's times.
`timescale 1ns / 1ps
`default_nettype none
module tset_cmp
    import tset_pkg::*;
(
    input  wire entry_t      entry,
    input  wire logic [47:0] key_start,
    input  wire logic [47:0] now_time,
    output cmp_t             flags
);
    logic [48:0] end_time;
    assign end_time = {1'b0, entry.start} + {17'd0, entry.length};
    assign flags.start_gt = entry.start > key_start;
    assign flags.started  = entry.start <= now_time;
    assign flags.ended    = end_time <= {1'b0, now_time};
endmodule
`default_nettype wire

FILE: rtl/time_sorted_event_table_top.sv
// Top level: sorted event table with sequencer, entry memory and compare unit.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to TABLE_DEPTH (N) events sorted by start time in a single-port-write,
// registered-read memory. One request is worked at a time; stall stays high
// until the request's last result is loaded into the output register. Insert
// walks the table from the top, moving one entry per step (read, then write).
// On a full table a first pass drops the earliest entry before the insert.
// Expire visits every held entry. Query visits held entries until the match
// limit is hit, passes through S_Q_OUT on each hit and ends with a final
// result. Clear goes straight to its result, as do query and expire on an
// empty table. Each entry step is paced by the memory port and the single
// compare unit. Query results leave one per accepted output, the table scan
// pausing while an earlier hit still waits for the output register. No
// clearing pass at reset: only slots below the entry count are ever read.
module time_sorted_event_table_top
    import tset_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire req_t in_data,
    output logic      out_valid,
    input  wire logic out_stall,
    output rsp_t      out_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_SHL_RD, S_SHL_WR, S_INS_RD, S_INS_CMP, S_INS_PUT,
        S_EXP_RD, S_EXP_CMP, S_Q_RD, S_Q_CMP, S_Q_OUT, S_Q_LAST, S_DONE
    } state_t;

    state_t state_reg;
    req_t   req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;     // read pointer
    logic [CNT_W-1:0] wr_reg;      // write pointer for expire
    logic [4:0]       found_reg;
    logic [4:0]       removed_reg;
    logic [4:0]       limit_reg;
    logic             out_valid_reg;
    rsp_t             out_reg;
    entry_t           pend_reg;    // query hit waiting for output slot

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;
    logic             mem_re;
    logic [IDX_W-1:0] mem_ra;

    cmp_t flags;
    tset_cmp u_cmp (
        .entry    (rd_data_reg),
        .key_start(req_reg.event_start),
        .now_time (req_reg.now_time),
        .flags    (flags)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    logic [4:0] cnt5;
    assign cnt5 = 5'(count_reg);

    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    logic q_hit;
    assign q_hit = flags.started && !flags.ended;

    entry_t new_entry;
    assign new_entry = '{req_reg.event_start, req_reg.event_length,
                         req_reg.event_payload};

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = new_entry;
        mem_re = 1'b0;
        mem_ra = '0;
        case (state_reg)
            S_SHL_RD, S_INS_RD, S_EXP_RD, S_Q_RD:
            begin
                mem_re = 1'b1;
                mem_ra = idx_reg[IDX_W-1:0];
            end
            S_SHL_WR:
            begin
                mem_we = 1'b1;
                mem_wa = IDX_W'(idx_reg - 1'b1);
                mem_wd = rd_data_reg;
            end
            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (flags.start_gt)
                begin
                    mem_wa = IDX_W'(idx_reg + 1'b1);
                    mem_wd = rd_data_reg;
                end
                else
                begin
                    mem_wa = IDX_W'(idx_reg + 1'b1);
                    mem_wd = new_entry;
                end
            end
            S_INS_PUT:
            begin
                mem_we = 1'b1;
                mem_wa = '0;
                mem_wd = new_entry;
            end
            S_EXP_CMP:
            begin
                mem_we = !flags.ended;
                mem_wa = wr_reg[IDX_W-1:0];
                mem_wd = rd_data_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Output register load: a held hit once a newer hit proves it is not
    // the last one, or the final result of a request.
    logic out_load;
    rsp_t out_next;

    always_comb
    begin
        out_load = 1'b0;
        out_next = '0;
        case (state_reg)
            S_Q_CMP:
            begin
                if (found_reg != limit_reg && found_reg != '0 && q_hit && out_free)
                begin
                    out_load = 1'b1;
                    out_next = '{1'b1, pend_reg.start, pend_reg.length,
                                 pend_reg.payload, 5'd0, cnt5, 1'b0};
                end
            end
            S_Q_LAST:
            begin
                out_load = out_free;
                out_next = '{(found_reg != '0),
                             (found_reg != '0) ? pend_reg.start : 48'd0,
                             (found_reg != '0) ? pend_reg.length : 32'd0,
                             (found_reg != '0) ? pend_reg.payload : 32'd0,
                             5'd0, cnt5, 1'b1};
            end
            S_DONE:
            begin
                out_load = out_free;
                out_next = '{1'b0, 48'd0, 32'd0, 32'd0,
                             (req_reg.mode == MODE_EXPIRE) ? removed_reg : 5'd0,
                             cnt5, 1'b1};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
            found_reg     <= '0;
            removed_reg   <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg     <= in_data;
                        found_reg   <= '0;
                        removed_reg <= '0;
                        limit_reg   <= (in_data.max_matches > 5'(MAX_RESULTS)) ?
                                       5'(MAX_RESULTS) : in_data.max_matches;
                        wr_reg      <= '0;
                        case (in_data.mode)
                            MODE_INSERT:
                            begin
                                if (count_reg == CNT_W'(TABLE_DEPTH))
                                begin
                                    idx_reg   <= CNT_W'(1);
                                    state_reg <= S_SHL_RD;
                                end
                                else if (count_reg == '0)
                                begin
                                    idx_reg   <= '0;
                                    state_reg <= S_INS_PUT;
                                end
                                else
                                begin
                                    idx_reg   <= count_reg - 1'b1;
                                    state_reg <= S_INS_RD;
                                end
                            end
                            MODE_QUERY:
                            begin
                                idx_reg   <= '0;
                                state_reg <= (count_reg == '0) ? S_Q_LAST : S_Q_RD;
                            end
                            MODE_EXPIRE:
                            begin
                                idx_reg   <= '0;
                                state_reg <= (count_reg == '0) ? S_DONE : S_EXP_RD;
                            end
                            default:
                            begin
                                idx_reg   <= '0;
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SHL_RD:
                begin
                    state_reg <= S_SHL_WR;
                end
                S_SHL_WR:
                begin
                    if (idx_reg == CNT_W'(TABLE_DEPTH - 1))
                    begin
                        count_reg <= CNT_W'(TABLE_DEPTH - 1);
                        idx_reg   <= CNT_W'(TABLE_DEPTH - 2);
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SHL_RD;
                    end
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS_CMP;
                end
                S_INS_CMP:
                begin
                    if (!flags.start_gt)
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                    else if (idx_reg == '0)
                    begin
                        state_reg <= S_INS_PUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= S_INS_RD;
                    end
                end
                S_INS_PUT:
                begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_EXP_RD:
                begin
                    state_reg <= S_EXP_CMP;
                end
                S_EXP_CMP:
                begin
                    if (flags.ended)
                    begin
                        removed_reg <= removed_reg + 1'b1;
                    end
                    else
                    begin
                        wr_reg <= wr_reg + 1'b1;
                    end
                    if (idx_reg + 1'b1 == count_reg)
                    begin
                        count_reg <= flags.ended ? wr_reg : wr_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_EXP_RD;
                    end
                end
                S_Q_RD:
                begin
                    state_reg <= S_Q_CMP;
                end
                S_Q_CMP:
                begin
                    if (found_reg == limit_reg)
                    begin
                        state_reg <= S_Q_LAST;
                    end
                    else if (q_hit)
                    begin
                        // Hold the compare while an earlier hit cannot be flushed.
                        if (found_reg == '0 || out_free)
                        begin
                            pend_reg  <= rd_data_reg;
                            found_reg <= found_reg + 1'b1;
                            state_reg <= S_Q_OUT;
                        end
                    end
                    else if (idx_reg + 1'b1 == count_reg)
                    begin
                        state_reg <= S_Q_LAST;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_Q_RD;
                    end
                end
                S_Q_OUT:
                begin
                    // The hit now waits in pend_reg until a later hit or the end proves
                    // whether it is the last result.
                    if (found_reg != limit_reg && idx_reg + 1'b1 != count_reg)
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_Q_RD;
                    end
                    else
                    begin
                        state_reg <= S_Q_LAST;
                    end
                end
                S_Q_LAST, S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH)) else $error("count overflow");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !in_stall) else $error("idle but stalled");
    a_found_lim: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= limit_reg) else $error("too many hits");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
endmodule
`default_nettype wire
